### rtl/core/mf3_pkg.sv
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int MIN_DIM        = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t hi;
        pix_t mid;
        pix_t lo;
    } col_t;

    typedef col_t [2:0] win_t;

    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } line_t;

    typedef struct packed {
        pix_t pix;
        logic emit;
        logic use_before;
        logic eor;
        logic eof;
    } item_t;

    typedef struct packed {
        pix_t prev_mid;
        logic use_before;
        logic eor;
        logic eof;
    } tag_t;

    function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t x0;
        pix_t x1;
        pix_t x2;
        pix_t t;
        col_t r;
        x0 = a;
        x1 = b;
        x2 = c;
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
        end
        if (x1 > x2) begin
            t = x1; x1 = x2; x2 = t;
        end
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
        end
        r.lo  = x0;
        r.mid = x1;
        r.hi  = x2;
        return r;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        col_t s;
        s = sort3(a, b, c);
        return s.mid;
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

### rtl/core/mf3_line_store.sv
// Two-row line store: one word per column holds the upper and middle row pixels.
// Synchronous memory with registered read and write-to-read bypass; uses mf3_pkg.
`timescale 1ns / 1ps

module mf3_line_store #(
    parameter int DEPTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(mf3_pkg::MAX_WIDTH_DEF)
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output mf3_pkg::line_t      rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  mf3_pkg::line_t      wr_data
);
    import mf3_pkg::*;

    line_t mem [DEPTH];
    line_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/mf3_ctrl.sv
// Frame geometry registers and the input and output position counters.
// Classifies each request and tags it for the window pipeline; uses mf3_pkg.
`timescale 1ns / 1ps

module mf3_ctrl #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mf3_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                accept,
    input  logic                                operation,
    input  mf3_pkg::pix_t                       pixel_value,
    output logic                                take,
    output logic [$clog2(MAX_WIDTH)-1:0]        addr,
    output mf3_pkg::item_t                      item
);
    import mf3_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

    function automatic logic [WDIM_W-1:0] clamp_w(input logic [FRAME_WIDTH_W-1:0] v);
        logic [WDIM_W-1:0] r;
        if (v < FRAME_WIDTH_W'(MIN_DIM)) begin
            r = WDIM_W'(MIN_DIM);
        end else if (32'(v) > MAX_WIDTH) begin
            r = WDIM_W'(MAX_WIDTH);
        end else begin
            r = WDIM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_h(input logic [FRAME_HEIGHT_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v < FRAME_HEIGHT_W'(MIN_DIM)) begin
            r = ROW_W'(MIN_DIM);
        end else if (32'(v) > MAX_HEIGHT) begin
            r = ROW_W'(MAX_HEIGHT);
        end else begin
            r = ROW_W'(v);
        end
        return r;
    endfunction

    logic [WDIM_W-1:0] width_reg, wm1_reg;
    logic [ROW_W-1:0]  height_reg, hm1_reg;
    logic [WDIM_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [WDIM_W-1:0] new_width;
    logic [ROW_W-1:0]  new_height;
    logic              draining, emit, border, eor, eof;

    assign new_width  = clamp_w(cfg_wdata[FRAME_WIDTH_W-1:0]);
    assign new_height = clamp_h(cfg_wdata[FRAME_HEIGHT_W-1:0]);

    assign draining = in_row_reg >= height_reg;
    assign take     = accept && ((operation == OP_PIXEL) || draining);
    assign emit     = (in_row_reg >= ROW_W'(2))
                   || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign border   = (out_row_reg == '0) || (out_row_reg >= hm1_reg)
                   || (out_col_reg == '0) || (out_col_reg >= wm1_reg);
    assign eor      = out_col_reg >= wm1_reg;
    assign eof      = eor && (out_row_reg >= hm1_reg);

    assign addr            = in_col_reg[ADDR_W-1:0];
    assign item.pix        = draining ? '0 : pixel_value;
    assign item.emit       = emit;
    assign item.use_before = (in_col_reg == '0) || border;
    assign item.eor        = eor;
    assign item.eof        = eof;

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (take) begin
            if (in_col_reg == wm1_reg) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + WDIM_W'(1);
            end
            if (emit) begin
                if (out_col_reg == wm1_reg) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + WDIM_W'(1);
                end
                if (eof) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= clamp_w(FRAME_WIDTH_W'(RESET_WIDTH));
            wm1_reg     <= clamp_w(FRAME_WIDTH_W'(RESET_WIDTH)) - WDIM_W'(1);
            height_reg  <= clamp_h(FRAME_HEIGHT_W'(RESET_HEIGHT));
            hm1_reg     <= clamp_h(FRAME_HEIGHT_W'(RESET_HEIGHT)) - ROW_W'(1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        width_reg <= new_width;
                        wm1_reg   <= new_width - WDIM_W'(1);
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg <= new_height;
                        hm1_reg    <= new_height - ROW_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    a_in_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_col_reg < width_reg)
        else $error("input column left the frame width");

    a_out_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_col_reg < width_reg) && (out_row_reg < height_reg))
        else $error("output position left the frame");

    a_eof_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        take && emit && eof |=> (in_col_reg == '0) && (in_row_reg == '0)
                                && (out_col_reg == '0) && (out_row_reg == '0))
        else $error("counters did not restart after the last result of a frame");

endmodule

### rtl/core/mf3_rank.sv
// Median pipeline over three column-sorted window columns, ending in the output register.
// Stages: window snapshot, max/median/min of rows, final median of three or border pixel; uses mf3_pkg.
`timescale 1ns / 1ps

module mf3_rank (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mf3_pkg::win_t   in_win,
    input  mf3_pkg::tag_t   in_tag,
    output logic            out_valid,
    input  logic            out_ready,
    output mf3_pkg::pix_t   out_value,
    output logic            out_eor,
    output logic            out_eof
);
    import mf3_pkg::*;

    logic  c_valid_reg, d_valid_reg, o_valid_reg;
    win_t  c_win_reg;
    tag_t  c_tag_reg, d_tag_reg;
    pix_t  d_lo_reg, d_mid_reg, d_hi_reg;
    pix_t  o_value_reg;
    logic  o_eor_reg, o_eof_reg;
    logic  o_free, d_free, c_free;

    assign o_free   = !o_valid_reg || out_ready;
    assign d_free   = !d_valid_reg || o_free;
    assign c_free   = !c_valid_reg || d_free;
    assign in_ready = c_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (c_free) begin
                c_valid_reg <= in_valid;
            end
            if (d_free) begin
                d_valid_reg <= c_valid_reg;
            end
            if (o_free) begin
                o_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && c_free) begin
            c_win_reg <= in_win;
            c_tag_reg <= in_tag;
        end
        if (c_valid_reg && d_free) begin
            d_lo_reg  <= max3(c_win_reg[0].lo, c_win_reg[1].lo, c_win_reg[2].lo);
            d_mid_reg <= med3(c_win_reg[0].mid, c_win_reg[1].mid, c_win_reg[2].mid);
            d_hi_reg  <= min3(c_win_reg[0].hi, c_win_reg[1].hi, c_win_reg[2].hi);
            d_tag_reg <= c_tag_reg;
        end
        if (d_valid_reg && o_free) begin
            o_value_reg <= d_tag_reg.use_before ? d_tag_reg.prev_mid
                                                : med3(d_lo_reg, d_mid_reg, d_hi_reg);
            o_eor_reg   <= d_tag_reg.eor;
            o_eof_reg   <= d_tag_reg.eof;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_value = o_value_reg;
    assign out_eor   = o_eor_reg;
    assign out_eof   = o_eof_reg;

    a_c_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !d_free |=> c_valid_reg && $stable(c_tag_reg))
        else $error("stalled window snapshot was lost or changed");

endmodule

### rtl/core/median_filter_3x3.sv
// Top level of the 3x3 median filter: request handling, line store access and window.
// Instantiates mf3_ctrl, mf3_line_store and mf3_rank; uses mf3_pkg.
//
// Usage: pixels of a frame arrive in raster order on the s_ channel (s_operation
// low, s_pixel_value). Each result on the m_ channel is the median of the 3x3
// neighborhood, or the pixel itself on the first and last rows and columns, with
// m_end_of_row and m_end_of_frame marking the row and frame ends. A result belongs
// to the pixel one row and one pixel before the request that releases it, so after
// the last pixel of a frame the source sends frame_width + 1 drain requests
// (s_operation high); drain requests sent while the frame is still arriving are
// dropped. m_valid rises once the releasing request has passed the line store
// stage and mf3_rank. One request is taken per clock unless the output stalls:
// each request reads and rewrites one line store word, and the comparator
// network is pipelined. frame_width and frame_height are written on the cfg_
// port while the block is idle; a write restarts the frame. Reset sets 640 by
// 480 and clears all position counters; the line stores need no clearing. When
// m_ready is low, up to three further requests are taken before s_ready drops.
`timescale 1ns / 1ps

module median_filter_3x3 #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mf3_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  mf3_pkg::pix_t                       s_pixel_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mf3_pkg::pix_t                       m_filtered_value,
    output logic                                m_end_of_row,
    output logic                                m_end_of_frame
);
    import mf3_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic              take;
    logic [ADDR_W-1:0] addr;
    item_t             item;

    logic              b_valid_reg;
    item_t             b_item_reg;
    logic [ADDR_W-1:0] b_addr_reg;
    logic              b_adv;

    line_t             rd_data;
    line_t             wr_data;
    col_t              new_col;
    col_t              col1_reg, col2_reg;
    pix_t              mid_last_reg;

    logic              rank_in_valid, rank_in_ready;
    win_t              rank_win;
    tag_t              rank_tag;

    mf3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept      (s_valid && s_ready),
        .operation   (s_operation),
        .pixel_value (s_pixel_value),
        .take        (take),
        .addr        (addr),
        .item        (item)
    );

    assign b_adv   = b_valid_reg && (!b_item_reg.emit || rank_in_ready);
    assign s_ready = !b_valid_reg || !b_item_reg.emit || rank_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_ready) begin
            b_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            b_item_reg <= item;
            b_addr_reg <= addr;
        end
    end

    assign wr_data.upper  = rd_data.middle;
    assign wr_data.middle = b_item_reg.pix;

    mf3_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (take),
        .rd_addr (addr),
        .rd_data (rd_data),
        .wr_en   (b_adv),
        .wr_addr (b_addr_reg),
        .wr_data (wr_data)
    );

    assign new_col = sort3(rd_data.upper, rd_data.middle, b_item_reg.pix);

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            col1_reg     <= col2_reg;
            col2_reg     <= new_col;
            mid_last_reg <= rd_data.middle;
        end
    end

    assign rank_in_valid       = b_valid_reg && b_item_reg.emit;
    assign rank_win[0]         = col1_reg;
    assign rank_win[1]         = col2_reg;
    assign rank_win[2]         = new_col;
    assign rank_tag.prev_mid   = mid_last_reg;
    assign rank_tag.use_before = b_item_reg.use_before;
    assign rank_tag.eor        = b_item_reg.eor;
    assign rank_tag.eof        = b_item_reg.eof;

    mf3_rank u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rank_in_valid),
        .in_ready  (rank_in_ready),
        .in_win    (rank_win),
        .in_tag    (rank_tag),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_value (m_filtered_value),
        .out_eor   (m_end_of_row),
        .out_eof   (m_end_of_frame)
    );

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !b_valid_reg |-> s_ready)
        else $error("request refused while the line store stage is empty");

endmodule
